// ----- sv/hcbd_pkg.sv -----
package hcbd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int BODY_BITS  = 32;

  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;

  localparam logic [BODY_BITS-1:0] MAX_BODY_RESET = BODY_BITS'(1048576);

  typedef logic [7:0]            byte_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BODY_BITS-1:0]  body_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_SIZE_LF = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_DATA_CR = 7'b0001000,
    PH_DATA_LF = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input byte_t c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- sv/hcbd_if.sv -----
interface hcbd_in_if import hcbd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  start_of_body;

  modport source (output valid, data_byte, start_of_body, input ready);
  modport sink   (input valid, data_byte, start_of_body, output ready);
endinterface

interface hcbd_out_if import hcbd_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_t      payload_byte;
  logic       payload_valid;
  logic [1:0] decode_status;

  modport source (output valid, payload_byte, payload_valid, decode_status, input ready);
  modport sink   (input valid, payload_byte, payload_valid, decode_status, output ready);
endinterface

interface hcbd_cfg_if import hcbd_pkg::*; ();
  logic  valid;
  logic  ready;
  body_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/http_chunked_body_decoder_core.sv -----
// channel     dir   payload
// body_in     in    data_byte[7:0], start_of_body
// result_out  out   payload_byte[7:0], payload_valid, decode_status[1:0]
// cfg         in    data[31:0] -> max_body_bytes
//
// One result per request; a request is taken every cycle while body_in.ready
// is high, its result registered for the next cycle (single result register).
// body_in.ready drops only while the result register is full and unclaimed.
// rst (synchronous) clears parse state and loads max_body_bytes = 1 MiB.
// cfg is always ready.
module http_chunked_body_decoder_core import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hcbd_in_if.sink    body_in,
  hcbd_out_if.source result_out,
  hcbd_cfg_if.sink   cfg
);

  body_t  max_body_bytes;
  phase_t phase, phase_next;
  count_t chunk_remaining, chunk_remaining_next;
  logic   size_line_empty, size_line_empty_next;
  body_t  body_count, body_count_next;

  logic  out_valid;
  byte_t out_byte;
  logic  out_pvalid;
  status_t out_status;

  phase_t ph_cur;
  count_t rem_cur, rem_dec;
  logic   empty_cur;
  body_t  cnt_cur;
  hex_t   hx;
  logic   res_pvalid;
  byte_t  res_byte;
  status_t res_status;
  logic   accept;

  assign cfg.ready     = 1'b1;
  assign body_in.ready = !out_valid || result_out.ready;
  assign accept        = body_in.valid && body_in.ready;

  always_comb begin
    ph_cur    = phase;
    rem_cur   = chunk_remaining;
    empty_cur = size_line_empty;
    cnt_cur   = body_count;
    if (body_in.start_of_body) begin
      ph_cur    = PH_SIZE;
      rem_cur   = '0;
      empty_cur = 1'b1;
      cnt_cur   = '0;
    end

    phase_next           = ph_cur;
    chunk_remaining_next = rem_cur;
    size_line_empty_next = empty_cur;
    body_count_next      = cnt_cur;
    res_pvalid           = 1'b0;
    res_byte             = '0;
    hx                   = hex_decode(body_in.data_byte);
    rem_dec              = rem_cur - count_t'(1);

    case (ph_cur)
      PH_SIZE: begin
        if (body_in.data_byte == BYTE_CR) begin
          phase_next = PH_SIZE_LF;
        end else if (!hx.ok || rem_cur[COUNT_BITS-1 -: 4] != 4'd0) begin
          phase_next = PH_ERROR;
        end else begin
          chunk_remaining_next = {rem_cur[COUNT_BITS-5:0], hx.value};
          size_line_empty_next = 1'b0;
        end
      end
      PH_SIZE_LF: begin
        if (body_in.data_byte != BYTE_LF) begin
          phase_next = PH_ERROR;
        end else if (empty_cur || rem_cur == '0) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (cnt_cur >= max_body_bytes) begin
          phase_next = PH_ERROR;
        end else begin
          res_pvalid           = 1'b1;
          res_byte             = body_in.data_byte;
          body_count_next      = cnt_cur + body_t'(1);
          chunk_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
      end
      PH_DATA_CR: begin
        phase_next = (body_in.data_byte == BYTE_CR) ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (body_in.data_byte == BYTE_LF) begin
          phase_next           = PH_SIZE;
          chunk_remaining_next = '0;
          size_line_empty_next = 1'b1;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    case (phase_next)
      PH_DONE:  res_status = ST_DONE;
      PH_ERROR: res_status = ST_ERROR;
      default:  res_status = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= MAX_BODY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_body_bytes <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      size_line_empty <= 1'b1;
      body_count      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      size_line_empty <= size_line_empty_next;
      body_count      <= body_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= res_byte;
      out_pvalid <= res_pvalid;
      out_status <= res_status;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.payload_byte  = out_byte;
  assign result_out.payload_valid = out_pvalid;
  assign result_out.decode_status = out_status;

`ifndef SYNTHESIS
  // a passed data byte never finishes or fails the body
  a_payload_in_progress: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.payload_valid |-> result_out.decode_status == ST_RUN)
    else $error("payload byte with terminal status");

  // non-payload results carry a zero byte
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.payload_valid |-> result_out.payload_byte == '0)
    else $error("nonzero byte on non-payload result");

  // apart from the start_of_body reset, body count moves by at most one per request, and only on a payload byte
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !body_in.start_of_body && !res_pvalid |=> $stable(body_count))
    else $error("body count changed without payload");
`endif

endmodule
